// ----- hdl/hsvtm_pkg.sv -----
// Shared types and constants for the HSV threshold mask pipeline.
// Used by hsvtm_div and hsv_threshold_mask; depends on nothing else.
package hsvtm_pkg;

  // Divider widths: dividends reach 2*255*255+255, divisors 2*255, quotients 255.
  localparam int NUM_W = 17;
  localparam int DEN_W = 9;
  localparam int QUO_W = 8;

  localparam logic [7:0] HUE_TOP = 8'd179;

  // APB address width: six registers at 4-byte spacing
  localparam int ADDR_W = 5;

  // Register indexes
  localparam logic [2:0] REG_HUE_LOW  = 3'd0;
  localparam logic [2:0] REG_HUE_HIGH = 3'd1;
  localparam logic [2:0] REG_SAT_LOW  = 3'd2;
  localparam logic [2:0] REG_SAT_HIGH = 3'd3;
  localparam logic [2:0] REG_VAL_LOW  = 3'd4;
  localparam logic [2:0] REG_VAL_HIGH = 3'd5;

  // Register reset values
  localparam logic [7:0] RST_HUE_LOW  = 8'd0;
  localparam logic [7:0] RST_HUE_HIGH = 8'd179;
  localparam logic [7:0] RST_SAT_LOW  = 8'd0;
  localparam logic [7:0] RST_SAT_HIGH = 8'd255;
  localparam logic [7:0] RST_VAL_LOW  = 8'd0;
  localparam logic [7:0] RST_VAL_HIGH = 8'd255;

  // Which channel holds the maximum
  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  // Per-pixel data that rides along the divider
  typedef struct packed {
    logic [7:0] brightness;
    logic       zero;
    logic       frame_end;
  } side_t;

endpackage

// ----- hdl/hsvtm_div.sv -----
// Dual-lane pipelined restoring divider, one quotient bit per stage.
// Depends on hsvtm_pkg for widths and the side-band struct.
module hsvtm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hsvtm_pkg::NUM_W-1:0]   num_a,
  input  logic [hsvtm_pkg::DEN_W-1:0]   den_a,
  input  logic [hsvtm_pkg::NUM_W-1:0]   num_b,
  input  logic [hsvtm_pkg::DEN_W-1:0]   den_b,
  input  hsvtm_pkg::side_t              side_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hsvtm_pkg::QUO_W-1:0]   quo_a,
  output logic [hsvtm_pkg::QUO_W-1:0]   quo_b,
  output hsvtm_pkg::side_t              side_out
);

  localparam int NW = hsvtm_pkg::NUM_W;
  localparam int DW = hsvtm_pkg::DEN_W;
  localparam int QW = hsvtm_pkg::QUO_W;

  logic [QW-1:0] vld;
  logic [QW:0]   rdy;

  logic [NW-1:0]    rem_a [QW];
  logic [NW-1:0]    rem_b [QW];
  logic [DW-1:0]    dv_a  [QW];
  logic [DW-1:0]    dv_b  [QW];
  logic [QW-1:0]    q_a   [QW];
  logic [QW-1:0]    q_b   [QW];
  hsvtm_pkg::side_t sd    [QW];

  logic [NW-1:0]    src_rem_a [QW];
  logic [NW-1:0]    src_rem_b [QW];
  logic [DW-1:0]    src_dv_a  [QW];
  logic [DW-1:0]    src_dv_b  [QW];
  logic [QW-1:0]    src_q_a   [QW];
  logic [QW-1:0]    src_q_b   [QW];
  hsvtm_pkg::side_t src_sd    [QW];

  logic [NW-1:0]    nxt_rem_a [QW];
  logic [NW-1:0]    nxt_rem_b [QW];
  logic [QW-1:0]    nxt_q_a   [QW];
  logic [QW-1:0]    nxt_q_b   [QW];

  // One compare-subtract against the divisor shifted to bit k
  function automatic logic [NW:0] div_step(input logic [NW-1:0] rem,
                                            input logic [DW-1:0] den,
                                            input int k);
    logic [NW-1:0] shifted;
    shifted = NW'(den) << k;
    if (rem >= shifted) begin
      div_step = {1'b1, rem - shifted};
    end else begin
      div_step = {1'b0, rem};
    end
  endfunction

  // Stage i may load when it is empty or its content moves on
  always_comb begin
    rdy[QW] = out_ready;
    for (int i = QW - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_ready = rdy[0];

  always_comb begin
    logic [NW:0] ra;
    logic [NW:0] rb;
    src_rem_a[0] = num_a;
    src_rem_b[0] = num_b;
    src_dv_a[0]  = den_a;
    src_dv_b[0]  = den_b;
    src_q_a[0]   = '0;
    src_q_b[0]   = '0;
    src_sd[0]    = side_in;
    for (int i = 1; i < QW; i++) begin
      src_rem_a[i] = rem_a[i-1];
      src_rem_b[i] = rem_b[i-1];
      src_dv_a[i]  = dv_a[i-1];
      src_dv_b[i]  = dv_b[i-1];
      src_q_a[i]   = q_a[i-1];
      src_q_b[i]   = q_b[i-1];
      src_sd[i]    = sd[i-1];
    end
    for (int i = 0; i < QW; i++) begin
      ra = div_step(src_rem_a[i], src_dv_a[i], QW - 1 - i);
      rb = div_step(src_rem_b[i], src_dv_b[i], QW - 1 - i);
      nxt_rem_a[i] = ra[NW-1:0];
      nxt_rem_b[i] = rb[NW-1:0];
      nxt_q_a[i] = src_q_a[i];
      nxt_q_b[i] = src_q_b[i];
      nxt_q_a[i][QW-1-i] = ra[NW];
      nxt_q_b[i][QW-1-i] = rb[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < QW; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QW; i++) begin
      if (rdy[i]) begin
        rem_a[i] <= nxt_rem_a[i];
        rem_b[i] <= nxt_rem_b[i];
        dv_a[i]  <= src_dv_a[i];
        dv_b[i]  <= src_dv_b[i];
        q_a[i]   <= nxt_q_a[i];
        q_b[i]   <= nxt_q_b[i];
        sd[i]    <= src_sd[i];
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quo_a     = q_a[QW-1];
  assign quo_b     = q_b[QW-1];
  assign side_out  = sd[QW-1];

endmodule

// ----- hdl/hsv_threshold_mask.sv -----
// BGR to HSV conversion with an HSV range mask, one pixel per cycle unless the output stalls.
// Registered stages from input request to output: range/sector, dividend,
// 8 divider stages, clamp and compare. Throughput: one pixel per cycle while m_tready is high.
// Rate is set by the 8-stage divider, one quotient bit per stage per lane.
// Reset (rst, synchronous): clears all valid bits, loads default bounds.
// Depends on hsvtm_pkg and hsvtm_div.
module hsv_threshold_mask (
  input  logic                         clk,
  input  logic                         rst,
  // s_tdata: blue[7:0], green[15:8], red[23:16]
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [23:0]                  s_tdata,
  input  logic                         s_tlast,
  // m_tdata: hue[7:0], saturation[15:8], brightness[23:16], in_range[24], zero fill
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [31:0]                  m_tdata,
  output logic                         m_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hsvtm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // Configuration registers
  logic [7:0] hue_low, hue_high, sat_low, sat_high, val_low, val_high;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[hsvtm_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_low  <= hsvtm_pkg::RST_HUE_LOW;
      hue_high <= hsvtm_pkg::RST_HUE_HIGH;
      sat_low  <= hsvtm_pkg::RST_SAT_LOW;
      sat_high <= hsvtm_pkg::RST_SAT_HIGH;
      val_low  <= hsvtm_pkg::RST_VAL_LOW;
      val_high <= hsvtm_pkg::RST_VAL_HIGH;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        hsvtm_pkg::REG_HUE_LOW:  hue_low  <= pwdata[7:0];
        hsvtm_pkg::REG_HUE_HIGH: hue_high <= pwdata[7:0];
        hsvtm_pkg::REG_SAT_LOW:  sat_low  <= pwdata[7:0];
        hsvtm_pkg::REG_SAT_HIGH: sat_high <= pwdata[7:0];
        hsvtm_pkg::REG_VAL_LOW:  val_low  <= pwdata[7:0];
        hsvtm_pkg::REG_VAL_HIGH: val_high <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      hsvtm_pkg::REG_HUE_LOW:  prdata = {24'd0, hue_low};
      hsvtm_pkg::REG_HUE_HIGH: prdata = {24'd0, hue_high};
      hsvtm_pkg::REG_SAT_LOW:  prdata = {24'd0, sat_low};
      hsvtm_pkg::REG_SAT_HIGH: prdata = {24'd0, sat_high};
      hsvtm_pkg::REG_VAL_LOW:  prdata = {24'd0, val_low};
      hsvtm_pkg::REG_VAL_HIGH: prdata = {24'd0, val_high};
      default:                 prdata = 32'd0;
    endcase
  end

  // Stage 1: max, min and the channel difference for the hue sector
  logic [7:0] blue, green, red;
  logic [7:0] mx_next, mn_next;
  logic [1:0] sec_next;
  logic signed [8:0] diff_next;

  assign blue  = s_tdata[7:0];
  assign green = s_tdata[15:8];
  assign red   = s_tdata[23:16];

  always_comb begin
    if (red >= green && red >= blue) begin
      sec_next  = hsvtm_pkg::SEC_RED;
      mx_next   = red;
      diff_next = signed'({1'b0, green}) - signed'({1'b0, blue});
    end else if (green >= blue) begin
      sec_next  = hsvtm_pkg::SEC_GREEN;
      mx_next   = green;
      diff_next = signed'({1'b0, blue}) - signed'({1'b0, red});
    end else begin
      sec_next  = hsvtm_pkg::SEC_BLUE;
      mx_next   = blue;
      diff_next = signed'({1'b0, red}) - signed'({1'b0, green});
    end
    mn_next = red;
    if (green < mn_next) mn_next = green;
    if (blue < mn_next) mn_next = blue;
  end

  logic              st1_v, st1_ready;
  logic [7:0]        st1_mx, st1_delta;
  logic [1:0]        st1_sec;
  logic signed [8:0] st1_diff;
  logic              st1_fe;

  logic              st2_v, st2_ready;
  logic              div_in_ready;

  assign st1_ready = !st1_v || st2_ready;
  assign s_tready  = st1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_v <= 1'b0;
    end else if (st1_ready) begin
      st1_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (st1_ready) begin
      st1_mx    <= mx_next;
      st1_delta <= mx_next - mn_next;
      st1_sec   <= sec_next;
      st1_diff  <= diff_next;
      st1_fe    <= s_tlast;
    end
  end

  // Stage 2: hue numerator base*delta + 30*diff, then rounding dividends
  logic [7:0]         hue_base;
  logic [15:0]        base_prod;
  logic signed [13:0] diff30;
  logic signed [18:0] hue_num;
  logic signed [18:0] hue_dvd;
  logic [16:0]        sat_dvd;

  always_comb begin
    case (st1_sec)
      hsvtm_pkg::SEC_RED:   hue_base = st1_diff[8] ? 8'd180 : 8'd0;
      hsvtm_pkg::SEC_GREEN: hue_base = 8'd60;
      hsvtm_pkg::SEC_BLUE:  hue_base = 8'd120;
      default:              hue_base = 8'd0;
    endcase
    base_prod = 16'(hue_base) * 16'(st1_delta);
    diff30    = 14'(st1_diff) * 14'sd30;
    hue_num   = signed'(19'(base_prod)) + 19'(diff30);
    hue_dvd   = (hue_num <<< 1) + signed'(19'(st1_delta));
    sat_dvd   = 17'(st1_delta) * 17'd510 + 17'(st1_mx);
  end

  logic [hsvtm_pkg::NUM_W-1:0] st2_num_h, st2_num_s;
  logic [hsvtm_pkg::DEN_W-1:0] st2_den_h, st2_den_s;
  hsvtm_pkg::side_t            st2_side;

  assign st2_ready = !st2_v || div_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st2_v <= 1'b0;
    end else if (st2_ready) begin
      st2_v <= st1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (st2_ready) begin
      st2_num_h <= hue_dvd[hsvtm_pkg::NUM_W-1:0];
      st2_num_s <= sat_dvd;
      st2_den_h <= {st1_delta, 1'b0};
      st2_den_s <= {st1_mx, 1'b0};
      st2_side.brightness <= st1_mx;
      st2_side.zero       <= (st1_delta == 8'd0);
      st2_side.frame_end  <= st1_fe;
    end
  end

  // Divider: hue on lane a, saturation on lane b
  logic                        div_out_v, div_out_ready;
  logic [hsvtm_pkg::QUO_W-1:0] q_hue, q_sat;
  hsvtm_pkg::side_t            div_side;

  hsvtm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st2_v),
    .in_ready  (div_in_ready),
    .num_a     (st2_num_h),
    .den_a     (st2_den_h),
    .num_b     (st2_num_s),
    .den_b     (st2_den_s),
    .side_in   (st2_side),
    .out_valid (div_out_v),
    .out_ready (div_out_ready),
    .quo_a     (q_hue),
    .quo_b     (q_sat),
    .side_out  (div_side)
  );

  // Output stage: grey pixels force zero, clamp hue, compare bounds
  logic [7:0] hue_next, sat_next, val_next;
  logic       in_range_next;
  logic       o_v;
  logic [7:0] o_hue, o_sat, o_val;
  logic       o_in_range, o_fe;

  always_comb begin
    if (div_side.zero) begin
      hue_next = 8'd0;
      sat_next = 8'd0;
    end else begin
      hue_next = (q_hue > hsvtm_pkg::HUE_TOP) ? hsvtm_pkg::HUE_TOP : q_hue;
      sat_next = q_sat;
    end
    val_next = div_side.brightness;
    in_range_next = (hue_next >= hue_low) && (hue_next <= hue_high) &&
                    (sat_next >= sat_low) && (sat_next <= sat_high) &&
                    (val_next >= val_low) && (val_next <= val_high);
  end

  assign div_out_ready = !o_v || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (div_out_ready) begin
      o_v <= div_out_v;
    end
  end

  always_ff @(posedge clk) begin
    if (div_out_ready) begin
      o_hue      <= hue_next;
      o_sat      <= sat_next;
      o_val      <= val_next;
      o_in_range <= in_range_next;
      o_fe       <= div_side.frame_end;
    end
  end

  assign m_tvalid = o_v;
  assign m_tdata  = {7'd0, o_in_range, o_val, o_sat, o_hue};
  assign m_tlast  = o_fe;

  // Input may stall only when the whole pipe is backed up behind the output
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (o_v && !m_tready))
    else $error("input stalled while the pipeline has room");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> st1_v)
    else $error("accepted request did not reach stage 1");

  a_hue_top: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] <= hsvtm_pkg::HUE_TOP))
    else $error("hue above 179 at output");

endmodule
